// ===== hw/rtl/spsl_pkg.sv =====
// Package for the servo pulse slew limiter: opcodes, error codes, register indexes,
// memory entry layouts and their reset values.
// No dependencies; imported by every module of the block.
package spsl_pkg;

   // widths of the fixed fields
   localparam int PULSE_W = 16;
   localparam int POS_W   = 8;
   localparam int SPD_W   = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // request opcodes
   typedef logic [1:0] opcode_type;
   localparam opcode_type OP_MOVE      = 2'd0;
   localparam opcode_type OP_TICK      = 2'd1;
   localparam opcode_type OP_RESET     = 2'd2;
   localparam opcode_type OP_SET_LIMIT = 2'd3;

   // latched error codes
   typedef logic [1:0] error_type;
   localparam error_type ERR_NONE  = 2'd0;
   localparam error_type ERR_INDEX = 2'd1;
   localparam error_type ERR_LIMIT = 2'd2;

   // configuration register indexes
   typedef logic [CSR_IDX_W-1:0] csr_index_type;
   localparam csr_index_type CSR_NEUTRAL_PULSE   = 3'd0;
   localparam csr_index_type CSR_PULSE_PER_UNIT  = 3'd1;
   localparam csr_index_type CSR_LIMIT_IS_ERROR  = 3'd2;
   localparam csr_index_type CSR_ABS_MIN_POS     = 3'd3;
   localparam csr_index_type CSR_ABS_MAX_POS     = 3'd4;
   localparam csr_index_type CSR_ABS_MAX_SPEED   = 3'd5;

   // register reset values
   localparam logic [PULSE_W-1:0]      NEUTRAL_RST    = 16'd30000;
   localparam logic [7:0]              PPU_RST        = 8'd100;
   localparam logic signed [POS_W-1:0] POS_LOW_RST    = -8'sd127;
   localparam logic signed [POS_W-1:0] POS_HIGH_RST   = 8'sd127;
   localparam logic [SPD_W-1:0]        SPEED_LIM_RST  = 8'd255;

   // per-servo motion entry: target and last command
   typedef struct packed {
      logic signed [POS_W-1:0] pos;
      logic [SPD_W-1:0]        spd;
      logic [PULSE_W-1:0]      cmd;
   } motion_entry_type;

   // per-servo limit entry
   typedef struct packed {
      logic signed [POS_W-1:0] lo;
      logic signed [POS_W-1:0] hi;
      logic [SPD_W-1:0]        sl;
   } limit_entry_type;

   localparam limit_entry_type LIMIT_ENTRY_RST = '{lo: POS_LOW_RST, hi: POS_HIGH_RST,
                                                  sl: SPEED_LIM_RST};

endpackage

// ===== hw/rtl/servo_pulse_slew_limiter_unit.sv =====
// Servo pulse slew limiter, top level: request sequencer, motion and limit memories,
// tick datapath. Depends on spsl_pkg and spsl_slew_calc.
//
// One request is worked at a time; req_ready is high only while the sequencer is idle.
// Per-servo state lives in two small synchronous memories (targets with commands, and
// limits) that are walked one entry at a time through a single datapath. A move or
// set-limit request reads and checks its entry; if it passes, it writes it and gives
// one status response. A tick, and the run of zero commands after an error, step each
// servo through read, multiply, add and update. A reset request checks every servo's
// stored limits, failing at the first bad one, else runs a full tick. Responses sit in
// an output register; a waiting response stalls only the update and status steps.
module servo_pulse_slew_limiter_unit #(
   parameter int SERVO_COUNT   = 8,
   parameter int FRACTION_BITS = 3
) (
   input  logic clock,
   input  logic reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [1:0]                           req_opcode,
   input  logic [7:0]                           req_servo_index,
   input  logic signed [spsl_pkg::POS_W-1:0]    req_position,
   input  logic [spsl_pkg::SPD_W-1:0]           req_speed,
   input  logic signed [spsl_pkg::POS_W-1:0]    req_new_limit_low,
   input  logic signed [spsl_pkg::POS_W-1:0]    req_new_limit_high,
   input  logic [spsl_pkg::SPD_W-1:0]           req_new_speed_limit,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_is_command,
   output logic [3:0]                           rsp_servo_number,
   output logic [spsl_pkg::PULSE_W-1:0]         rsp_pulse_command,
   output logic                                 rsp_failed,
   output logic [1:0]                           rsp_error_state,
   output logic                                 rsp_last,
   // configuration write channel
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [spsl_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [spsl_pkg::CSR_DATA_W-1:0]      csr_data
);
   import spsl_pkg::*;

   localparam int IDX_W = (SERVO_COUNT > 1) ? $clog2(SERVO_COUNT) : 1;

   typedef enum logic [9:0] {
      ST_IDLE     = 10'b00_0000_0001,
      ST_SEL_RD   = 10'b00_0000_0010,
      ST_SEL_CHK  = 10'b00_0000_0100,
      ST_CHK_RD   = 10'b00_0000_1000,
      ST_CHK_EVAL = 10'b00_0001_0000,
      ST_RUN_RD   = 10'b00_0010_0000,
      ST_RUN_MUL  = 10'b00_0100_0000,
      ST_RUN_ADD  = 10'b00_1000_0000,
      ST_RUN_OUT  = 10'b01_0000_0000,
      ST_STATUS   = 10'b10_0000_0000
   } state_type;

   // configuration registers
   logic [PULSE_W-1:0]      neutral_ff;
   logic [7:0]              ppu_ff;
   logic                    lim_is_err_ff;
   logic signed [POS_W-1:0] abs_min_ff;
   logic signed [POS_W-1:0] abs_max_ff;
   logic [SPD_W-1:0]        abs_spd_ff;

   // sequencer
   state_type        state_ff, state_in;
   logic [IDX_W-1:0] cnt_ff, cnt_in;
   logic             fail_ff, fail_in;
   error_type        err_ff, err_in;

   // captured request
   opcode_type              op_ff;
   logic [7:0]              idx_ff;
   logic signed [POS_W-1:0] pos_ff;
   logic [SPD_W-1:0]        spd_ff;
   logic signed [POS_W-1:0] lo_ff;
   logic signed [POS_W-1:0] hi_ff;
   logic [SPD_W-1:0]        sl_ff;

   // memories with valid bits; an entry not yet written reads as its reset value
   motion_entry_type        mot_mem [SERVO_COUNT];
   limit_entry_type         lim_mem [SERVO_COUNT];
   logic [SERVO_COUNT-1:0]  mot_vld_ff;
   logic [SERVO_COUNT-1:0]  lim_vld_ff;
   motion_entry_type        mot_rd_ff;
   limit_entry_type         lim_rd_ff;
   logic                    mot_rd_vld_ff;
   logic                    lim_rd_vld_ff;
   motion_entry_type        mot_rd;
   limit_entry_type         lim_rd;
   logic [IDX_W-1:0]        mem_addr;
   logic                    mem_re;
   logic                    mot_we;
   logic                    lim_we;
   logic                    mot_clear;
   motion_entry_type        mot_wdata;
   limit_entry_type         lim_wdata;

   // tick datapath
   logic signed [16:0]  prod_pos;
   logic [PULSE_W-1:0]  prod_pos_ff;
   logic [PULSE_W-1:0]  step_ff;
   logic [PULSE_W-1:0]  target_ff;
   logic [PULSE_W-1:0]  start_ff;
   logic [PULSE_W-1:0]  start_scaled;
   logic [PULSE_W-1:0]  next_pulse;
   logic [PULSE_W-1:0]  new_cmd;

   // response register
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_cmd_ff, rsp_cmd_in;
   logic [3:0]          rsp_num_ff, rsp_num_in;
   logic [PULSE_W-1:0]  rsp_pulse_ff, rsp_pulse_in;
   logic                rsp_fail_ff, rsp_fail_in;
   error_type           rsp_err_ff, rsp_err_in;
   logic                rsp_last_ff, rsp_last_in;
   logic                out_free;
   logic                out_load;

   // checks
   logic cnt_last;
   logic req_fire;
   logic idx_bad;
   logic pos_below;
   logic pos_above;
   logic spd_bad;
   logic move_bad;
   logic setlim_bad;
   logic stored_bad;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign cnt_last  = (cnt_ff == IDX_W'(SERVO_COUNT - 1));
   assign idx_bad   = (req_servo_index >= 8'(SERVO_COUNT));
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         neutral_ff    <= NEUTRAL_RST;
         ppu_ff        <= PPU_RST;
         lim_is_err_ff <= 1'b0;
         abs_min_ff    <= POS_LOW_RST;
         abs_max_ff    <= POS_HIGH_RST;
         abs_spd_ff    <= SPEED_LIM_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_NEUTRAL_PULSE:  neutral_ff    <= csr_data;
            CSR_PULSE_PER_UNIT: ppu_ff        <= csr_data[7:0];
            CSR_LIMIT_IS_ERROR: lim_is_err_ff <= csr_data[0];
            CSR_ABS_MIN_POS:    abs_min_ff    <= $signed(csr_data[POS_W-1:0]);
            CSR_ABS_MAX_POS:    abs_max_ff    <= $signed(csr_data[POS_W-1:0]);
            CSR_ABS_MAX_SPEED:  abs_spd_ff    <= csr_data[SPD_W-1:0];
            default: ;
         endcase
      end
   end

   // memory address: the addressed servo for move and set limits, else the walk counter
   assign mem_addr = (state_ff == ST_SEL_RD || state_ff == ST_SEL_CHK) ?
                     idx_ff[IDX_W-1:0] : cnt_ff;
   assign mem_re   = (state_ff == ST_SEL_RD) || (state_ff == ST_CHK_RD) ||
                     (state_ff == ST_RUN_RD);

   // motion and limit memories
   always_ff @(posedge clock) begin
      if (mot_we) begin
         mot_mem[mem_addr] <= mot_wdata;
      end
      if (lim_we) begin
         lim_mem[mem_addr] <= lim_wdata;
      end
      if (mem_re) begin
         mot_rd_ff <= mot_mem[mem_addr];
         lim_rd_ff <= lim_mem[mem_addr];
      end
   end

   // valid bits, read valid follows read data
   always_ff @(posedge clock) begin
      if (reset) begin
         mot_vld_ff    <= '0;
         lim_vld_ff    <= '0;
         mot_rd_vld_ff <= 1'b0;
         lim_rd_vld_ff <= 1'b0;
      end else begin
         if (mot_clear) begin
            mot_vld_ff <= '0;
         end else if (mot_we) begin
            mot_vld_ff[mem_addr] <= 1'b1;
         end
         if (lim_we) begin
            lim_vld_ff[mem_addr] <= 1'b1;
         end
         if (mem_re) begin
            mot_rd_vld_ff <= mot_vld_ff[mem_addr];
            lim_rd_vld_ff <= lim_vld_ff[mem_addr];
         end
      end
   end

   assign mot_rd = mot_rd_vld_ff ? mot_rd_ff : '0;
   assign lim_rd = lim_rd_vld_ff ? lim_rd_ff : LIMIT_ENTRY_RST;

   // move and set-limit checks against the addressed entry
   assign pos_below  = (pos_ff < lim_rd.lo);
   assign pos_above  = (pos_ff > lim_rd.hi);
   assign spd_bad    = (spd_ff > lim_rd.sl) || (spd_ff == '0);
   assign move_bad   = lim_is_err_ff && (pos_below || pos_above || spd_bad);
   assign setlim_bad = (lo_ff < abs_min_ff) || (hi_ff > abs_max_ff) || (lo_ff >= hi_ff) ||
                       (sl_ff > abs_spd_ff);
   assign stored_bad = (lim_rd.lo >= lim_rd.hi) || (lim_rd.lo < abs_min_ff) ||
                       (lim_rd.hi > abs_max_ff) || (lim_rd.sl > abs_spd_ff);

   // tick datapath: multiply, then target and start, then slew step
   assign prod_pos     = $signed({1'b0, ppu_ff}) * mot_rd.pos;
   assign start_scaled = mot_rd.cmd << FRACTION_BITS;

   always_ff @(posedge clock) begin
      if (state_ff == ST_RUN_MUL) begin
         prod_pos_ff <= prod_pos[PULSE_W-1:0];
         step_ff     <= PULSE_W'(ppu_ff * mot_rd.spd);
      end
      if (state_ff == ST_RUN_ADD) begin
         target_ff <= neutral_ff + prod_pos_ff;
         start_ff  <= (mot_rd.cmd == '0) ? neutral_ff : start_scaled;
      end
   end

   spsl_slew_calc u_slew (
      .start      (start_ff),
      .target     (target_ff),
      .step       (step_ff),
      .next_pulse (next_pulse)
   );

   assign new_cmd = (err_ff != ERR_NONE) ? '0 : (next_pulse >> FRACTION_BITS);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      fail_in      = fail_ff;
      err_in       = err_ff;
      mot_we       = 1'b0;
      lim_we       = 1'b0;
      mot_clear    = 1'b0;
      mot_wdata    = mot_rd;
      lim_wdata    = '{lo: lo_ff, hi: hi_ff, sl: sl_ff};
      out_load     = 1'b0;
      rsp_cmd_in   = 1'b0;
      rsp_num_in   = '0;
      rsp_pulse_in = '0;
      rsp_fail_in  = fail_ff;
      rsp_err_in   = err_ff;
      rsp_last_in  = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cnt_in  = '0;
               fail_in = 1'b0;
               if (req_opcode == OP_TICK) begin
                  state_in = ST_RUN_RD;
               end else if (req_opcode == OP_RESET) begin
                  state_in = ST_CHK_RD;
               end else if (idx_bad) begin
                  err_in   = ERR_INDEX;
                  fail_in  = 1'b1;
                  state_in = ST_RUN_RD;
               end else begin
                  state_in = ST_SEL_RD;
               end
            end
         end
         ST_SEL_RD: begin
            state_in = ST_SEL_CHK;
         end
         ST_SEL_CHK: begin
            if (op_ff == OP_MOVE) begin
               if (move_bad) begin
                  err_in   = ERR_LIMIT;
                  fail_in  = 1'b1;
                  state_in = ST_RUN_RD;
               end else begin
                  mot_we        = 1'b1;
                  mot_wdata.pos = pos_below ? lim_rd.lo : (pos_above ? lim_rd.hi : pos_ff);
                  mot_wdata.spd = spd_bad ? lim_rd.sl : spd_ff;
                  state_in      = ST_STATUS;
               end
            end else begin
               if (setlim_bad) begin
                  err_in   = ERR_LIMIT;
                  fail_in  = 1'b1;
                  state_in = ST_RUN_RD;
               end else begin
                  lim_we   = 1'b1;
                  state_in = ST_STATUS;
               end
            end
         end
         ST_CHK_RD: begin
            state_in = ST_CHK_EVAL;
         end
         ST_CHK_EVAL: begin
            if (stored_bad) begin
               fail_in  = 1'b1;
               state_in = ST_STATUS;
            end else if (cnt_last) begin
               // limits pass: clear error, targets and commands, then tick
               err_in    = ERR_NONE;
               mot_clear = 1'b1;
               cnt_in    = '0;
               state_in  = ST_RUN_RD;
            end else begin
               cnt_in   = cnt_ff + 1'b1;
               state_in = ST_CHK_RD;
            end
         end
         ST_RUN_RD: begin
            state_in = ST_RUN_MUL;
         end
         ST_RUN_MUL: begin
            state_in = ST_RUN_ADD;
         end
         ST_RUN_ADD: begin
            state_in = ST_RUN_OUT;
         end
         ST_RUN_OUT: begin
            // write back and emit once the response register is free
            if (out_free) begin
               mot_we        = 1'b1;
               mot_wdata.cmd = new_cmd;
               out_load      = 1'b1;
               rsp_cmd_in    = 1'b1;
               rsp_num_in    = 4'(cnt_ff);
               rsp_pulse_in  = new_cmd;
               rsp_last_in   = cnt_last;
               if (cnt_last) begin
                  state_in = ST_IDLE;
               end else begin
                  cnt_in   = cnt_ff + 1'b1;
                  state_in = ST_RUN_RD;
               end
            end
         end
         ST_STATUS: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // response valid
   always_comb begin
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         fail_ff      <= 1'b0;
         err_ff       <= ERR_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         fail_ff      <= fail_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // request capture and response payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff  <= req_opcode;
         idx_ff <= req_servo_index;
         pos_ff <= req_position;
         spd_ff <= req_speed;
         lo_ff  <= req_new_limit_low;
         hi_ff  <= req_new_limit_high;
         sl_ff  <= req_new_speed_limit;
      end
      if (out_load) begin
         rsp_cmd_ff   <= rsp_cmd_in;
         rsp_num_ff   <= rsp_num_in;
         rsp_pulse_ff <= rsp_pulse_in;
         rsp_fail_ff  <= rsp_fail_in;
         rsp_err_ff   <= rsp_err_in;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_is_command    = rsp_cmd_ff;
   assign rsp_servo_number  = rsp_num_ff;
   assign rsp_pulse_command = rsp_pulse_ff;
   assign rsp_failed        = rsp_fail_ff;
   assign rsp_error_state   = rsp_err_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

// ===== hw/rtl/spsl_slew_calc.sv =====
// One slew step of a servo pulse: moves the start pulse toward the target by at most
// the step, with 16-bit wrapping arithmetic. Uses spsl_pkg.
module spsl_slew_calc (
   input  logic [spsl_pkg::PULSE_W-1:0] start,
   input  logic [spsl_pkg::PULSE_W-1:0] target,
   input  logic [spsl_pkg::PULSE_W-1:0] step,
   output logic [spsl_pkg::PULSE_W-1:0] next_pulse
);
   import spsl_pkg::*;

   logic [PULSE_W-1:0] diff;
   logic [PULSE_W-1:0] span;

   // wrapped difference, magnitude taken as signed (0x8000 stays 32768)
   assign diff = start - target;
   assign span = diff[PULSE_W-1] ? (~diff + 1'b1) : diff;

   // jump when close, else step toward target
   always_comb begin
      if (span < step) begin
         next_pulse = target;
      end else if (target > start) begin
         next_pulse = start + step;
      end else begin
         next_pulse = start - step;
      end
   end

endmodule

// ===== sim/servo_pulse_checker.sv =====
`timescale 1ns / 1ps
// Response checker for the servo pulse slew limiter: follows the request, response and
// register write channels, predicts every response and compares it field by field.
// Depends on spsl_pkg.
module servo_pulse_checker #(
   parameter int SERVO_COUNT   = 8,
   parameter int FRACTION_BITS = 3
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_ready,
   input  logic [1:0]                         req_opcode,
   input  logic [7:0]                         req_servo_index,
   input  logic signed [spsl_pkg::POS_W-1:0]  req_position,
   input  logic [spsl_pkg::SPD_W-1:0]         req_speed,
   input  logic signed [spsl_pkg::POS_W-1:0]  req_new_limit_low,
   input  logic signed [spsl_pkg::POS_W-1:0]  req_new_limit_high,
   input  logic [spsl_pkg::SPD_W-1:0]         req_new_speed_limit,
   input  logic                               rsp_valid,
   input  logic                               rsp_ready,
   input  logic                               rsp_is_command,
   input  logic [3:0]                         rsp_servo_number,
   input  logic [spsl_pkg::PULSE_W-1:0]       rsp_pulse_command,
   input  logic                               rsp_failed,
   input  logic [1:0]                         rsp_error_state,
   input  logic                               rsp_last,
   input  logic                               csr_valid,
   input  logic                               csr_ready,
   input  logic [spsl_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [spsl_pkg::CSR_DATA_W-1:0]    csr_data,
   output int                                 fail_count,
   output int                                 pending_count
);
   import spsl_pkg::*;

   typedef struct packed {
      logic               is_command;
      logic [3:0]         servo_number;
      logic [PULSE_W-1:0] pulse_command;
      logic               failed;
      error_type          error_state;
      logic               last;
   } pulse_result_t;

   pulse_result_t expected_results[$];
   int            mismatches;

   // register copies
   logic [PULSE_W-1:0]      neutral_q;
   logic [7:0]              per_unit_q;
   logic                    strict_q;
   logic signed [POS_W-1:0] abs_min_q;
   logic signed [POS_W-1:0] abs_max_q;
   logic [SPD_W-1:0]        abs_speed_q;

   // per-servo state copies
   logic signed [POS_W-1:0] goal_pos    [SERVO_COUNT];
   logic [SPD_W-1:0]        target_spd  [SERVO_COUNT];
   logic [PULSE_W-1:0]      pulse_cmd   [SERVO_COUNT];
   logic signed [POS_W-1:0] limit_lo    [SERVO_COUNT];
   logic signed [POS_W-1:0] limit_hi    [SERVO_COUNT];
   logic [SPD_W-1:0]        limit_speed [SERVO_COUNT];
   error_type               fault_code;

   // power-up state
   task automatic clear_all();
      neutral_q   = NEUTRAL_RST;
      per_unit_q  = PPU_RST;
      strict_q    = 1'b0;
      abs_min_q   = POS_LOW_RST;
      abs_max_q   = POS_HIGH_RST;
      abs_speed_q = SPEED_LIM_RST;
      for (int i = 0; i < SERVO_COUNT; i++) begin
         goal_pos[i]    = '0;
         target_spd[i]  = '0;
         pulse_cmd[i]   = '0;
         limit_lo[i]    = POS_LOW_RST;
         limit_hi[i]    = POS_HIGH_RST;
         limit_speed[i] = SPEED_LIM_RST;
      end
      fault_code = ERR_NONE;
      expected_results.delete();
   endtask

   task automatic push_status(logic failed);
      pulse_result_t r;
      r.is_command    = 1'b0;
      r.servo_number  = '0;
      r.pulse_command = '0;
      r.failed        = failed;
      r.error_state   = fault_code;
      r.last          = 1'b1;
      expected_results.push_back(r);
   endtask

   // one command per servo; a latched fault forces every command to zero
   task automatic push_command_run(logic failed);
      pulse_result_t r;
      if (fault_code != ERR_NONE)
         for (int i = 0; i < SERVO_COUNT; i++) pulse_cmd[i] = '0;
      for (int i = 0; i < SERVO_COUNT; i++) begin
         r.is_command    = 1'b1;
         r.servo_number  = 4'(i);
         r.pulse_command = pulse_cmd[i];
         r.failed        = failed;
         r.error_state   = fault_code;
         r.last          = (i == SERVO_COUNT - 1);
         expected_results.push_back(r);
      end
   endtask

   task automatic latch_fault(error_type code);
      fault_code = code;
      push_command_run(1'b1);
   endtask

   // slew every servo one step toward its target pulse, 16-bit wrapping
   task automatic advance_pulses(logic failed);
      int start, goal, step, span, next;
      for (int i = 0; i < SERVO_COUNT; i++) begin
         if (pulse_cmd[i] == '0)
            start = int'(neutral_q);
         else
            start = (int'(pulse_cmd[i]) << FRACTION_BITS) & 32'hFFFF;
         goal = (int'(neutral_q) + int'(per_unit_q) * int'(goal_pos[i])) & 32'hFFFF;
         step = (int'(per_unit_q) * int'(target_spd[i])) & 32'hFFFF;
         span = (start - goal) & 32'hFFFF;
         if (span >= 32'h8000)
            span = (32'h10000 - span) & 32'hFFFF;
         if (span < step)
            next = goal;
         else if (goal > start)
            next = (start + step) & 32'hFFFF;
         else
            next = (start - step) & 32'hFFFF;
         pulse_cmd[i] = 16'(next >> FRACTION_BITS);
      end
      push_command_run(failed);
   endtask

   function automatic bit limits_broken();
      for (int i = 0; i < SERVO_COUNT; i++) begin
         if (limit_lo[i] >= limit_hi[i] || limit_lo[i] < abs_min_q ||
             limit_hi[i] > abs_max_q || limit_speed[i] > abs_speed_q)
            return 1'b1;
      end
      return 1'b0;
   endfunction

   task automatic predict_request(opcode_type op, logic [7:0] idx,
                                  logic signed [POS_W-1:0] pos, logic [SPD_W-1:0] spd,
                                  logic signed [POS_W-1:0] lo, logic signed [POS_W-1:0] hi,
                                  logic [SPD_W-1:0] sl);
      logic signed [POS_W-1:0] new_pos;
      logic [SPD_W-1:0]        new_spd;
      bit                      bad;
      new_pos = pos;
      new_spd = spd;
      bad     = 1'b0;
      case (op)
         OP_TICK: advance_pulses(1'b0);
         OP_RESET: begin
            if (limits_broken()) begin
               push_status(1'b1);
            end else begin
               fault_code = ERR_NONE;
               for (int i = 0; i < SERVO_COUNT; i++) begin
                  goal_pos[i]   = '0;
                  target_spd[i] = '0;
                  pulse_cmd[i]  = '0;
               end
               advance_pulses(1'b0);
            end
         end
         default: begin
            if (idx >= SERVO_COUNT) begin
               latch_fault(ERR_INDEX);
            end else if (op == OP_MOVE) begin
               // out-of-limit values are clipped unless strict mode is on
               if (pos < limit_lo[idx] || pos > limit_hi[idx]) begin
                  if (strict_q) bad = 1'b1;
                  else new_pos = (pos < limit_lo[idx]) ? limit_lo[idx] : limit_hi[idx];
               end
               if (!bad && (spd > limit_speed[idx] || spd == '0)) begin
                  if (strict_q) bad = 1'b1;
                  else new_spd = limit_speed[idx];
               end
               if (bad) begin
                  latch_fault(ERR_LIMIT);
               end else begin
                  goal_pos[idx]   = new_pos;
                  target_spd[idx] = new_spd;
                  push_status(1'b0);
               end
            end else begin
               if (lo < abs_min_q || hi > abs_max_q || lo >= hi || sl > abs_speed_q) begin
                  latch_fault(ERR_LIMIT);
               end else begin
                  limit_lo[idx]    = lo;
                  limit_hi[idx]    = hi;
                  limit_speed[idx] = sl;
                  push_status(1'b0);
               end
            end
         end
      endcase
   endtask

   task automatic apply_csr(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_NEUTRAL_PULSE:  neutral_q   = data[15:0];
         CSR_PULSE_PER_UNIT: per_unit_q  = data[7:0];
         CSR_LIMIT_IS_ERROR: strict_q    = data[0];
         CSR_ABS_MIN_POS:    abs_min_q   = data[7:0];
         CSR_ABS_MAX_POS:    abs_max_q   = data[7:0];
         CSR_ABS_MAX_SPEED:  abs_speed_q = data[7:0];
         default: ;
      endcase
   endtask

   function automatic int field_diff(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         return 1;
      end
      return 0;
   endfunction

   // sample all channels at the clock edge
   always @(posedge clock) begin
      pulse_result_t want;
      if (reset) begin
         clear_all();
         mismatches = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $display("%0t ns: unexpected response, expected none, actual cmd %0b servo %0d",
                        $time, rsp_is_command, rsp_servo_number);
               mismatches++;
            end else begin
               want = expected_results.pop_front();
               mismatches += field_diff("is_command", want.is_command, rsp_is_command);
               mismatches += field_diff("servo_number", want.servo_number, rsp_servo_number);
               mismatches += field_diff("pulse_command", want.pulse_command,
                                        rsp_pulse_command);
               mismatches += field_diff("failed", want.failed, rsp_failed);
               mismatches += field_diff("error_state", want.error_state, rsp_error_state);
               mismatches += field_diff("last", want.last, rsp_last);
            end
         end
         if (csr_valid && csr_ready)
            apply_csr(csr_index, csr_data);
         if (req_valid && req_ready)
            predict_request(req_opcode, req_servo_index, req_position, req_speed,
                            req_new_limit_low, req_new_limit_high, req_new_speed_limit);
      end
      pending_count <= expected_results.size();
      fail_count    <= mismatches;
   end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the servo pulse slew limiter: clock, reset, request and register
// stimulus, response back-pressure and the verdict.
// Depends on spsl_pkg, servo_pulse_slew_limiter_unit and servo_pulse_checker.
module tb;
   import spsl_pkg::*;

   localparam int SERVO_COUNT   = 8;
   localparam int FRACTION_BITS = 3;
   localparam int RANDOM_ITEMS  = 210;
   localparam int PHASES        = 5;
   // index with no register behind it
   localparam csr_index_type CSR_SPARE = 3'd7;

   logic clock = 1'b0;
   logic reset;

   logic                    req_valid;
   logic                    req_ready;
   opcode_type              req_opcode;
   logic [7:0]              req_servo_index;
   logic signed [POS_W-1:0] req_position;
   logic [SPD_W-1:0]        req_speed;
   logic signed [POS_W-1:0] req_new_limit_low;
   logic signed [POS_W-1:0] req_new_limit_high;
   logic [SPD_W-1:0]        req_new_speed_limit;

   logic                    rsp_valid;
   logic                    rsp_ready;
   logic                    rsp_is_command;
   logic [3:0]              rsp_servo_number;
   logic [PULSE_W-1:0]      rsp_pulse_command;
   logic                    rsp_failed;
   logic [1:0]              rsp_error_state;
   logic                    rsp_last;

   logic                    csr_valid;
   logic                    csr_ready;
   csr_index_type           csr_index;
   logic [CSR_DATA_W-1:0]   csr_data;

   int fail_count;
   int pending_count;

   // limit registers as last written, used to aim set-limit requests at legal values
   int cur_abs_min;
   int cur_abs_max;
   int cur_abs_spd;
   bit no_gaps;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   servo_pulse_slew_limiter_unit #(
      .SERVO_COUNT(SERVO_COUNT),
      .FRACTION_BITS(FRACTION_BITS)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_opcode(req_opcode),
      .req_servo_index(req_servo_index),
      .req_position(req_position),
      .req_speed(req_speed),
      .req_new_limit_low(req_new_limit_low),
      .req_new_limit_high(req_new_limit_high),
      .req_new_speed_limit(req_new_speed_limit),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_is_command(rsp_is_command),
      .rsp_servo_number(rsp_servo_number),
      .rsp_pulse_command(rsp_pulse_command),
      .rsp_failed(rsp_failed),
      .rsp_error_state(rsp_error_state),
      .rsp_last(rsp_last),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   servo_pulse_checker #(
      .SERVO_COUNT(SERVO_COUNT),
      .FRACTION_BITS(FRACTION_BITS)
   ) u_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_opcode(req_opcode),
      .req_servo_index(req_servo_index),
      .req_position(req_position),
      .req_speed(req_speed),
      .req_new_limit_low(req_new_limit_low),
      .req_new_limit_high(req_new_limit_high),
      .req_new_speed_limit(req_new_speed_limit),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_is_command(rsp_is_command),
      .rsp_servo_number(rsp_servo_number),
      .rsp_pulse_command(rsp_pulse_command),
      .rsp_failed(rsp_failed),
      .rsp_error_state(rsp_error_state),
      .rsp_last(rsp_last),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .fail_count(fail_count),
      .pending_count(pending_count)
   );

   // response back-pressure: runs of ready, short stalls, now and then a long one
   initial begin
      int hi_run, lo_run;
      forever begin
         hi_run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 20);
         lo_run = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
         rsp_ready <= 1'b1;
         repeat (hi_run) @(posedge clock);
         rsp_ready <= 1'b0;
         repeat (lo_run) @(posedge clock);
      end
   end

   // run limit
   initial begin
      #10_000_000;
      $display("Verification failed");
      $finish;
   end

   function automatic logic [7:0] any8();
      return 8'($urandom);
   endfunction

   // present one request and hold it until accepted, then maybe leave a gap
   task automatic send_request(opcode_type op, logic [7:0] idx, logic [7:0] pos,
                               logic [7:0] spd, logic [7:0] lo, logic [7:0] hi,
                               logic [7:0] sl);
      int gap, r;
      req_opcode          <= op;
      req_servo_index     <= idx;
      req_position        <= pos;
      req_speed           <= spd;
      req_new_limit_low   <= lo;
      req_new_limit_high  <= hi;
      req_new_speed_limit <= sl;
      req_valid           <= 1'b1;
      do @(posedge clock); while (!req_ready);
      r = $urandom_range(0, 99);
      if (no_gaps || r < 60) gap = 0;
      else if (r < 90) gap = $urandom_range(1, 3);
      else gap = $urandom_range(10, 40);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // hold off new requests until every predicted response has come back
   task automatic drain_responses();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   // register write; valid stays high across back-to-back writes
   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
      csr_index <= idx;
      csr_data  <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
   endtask

   // rewrite every register, unused upper data bits random
   task automatic program_config(logic [15:0] neutral, logic [7:0] per_unit, logic strict,
                                 int abs_min, int abs_max, int abs_spd);
      write_reg(CSR_NEUTRAL_PULSE, neutral);
      write_reg(CSR_PULSE_PER_UNIT, {any8(), per_unit});
      write_reg(CSR_LIMIT_IS_ERROR, {15'($urandom), strict});
      write_reg(CSR_ABS_MIN_POS, {any8(), 8'(abs_min)});
      write_reg(CSR_ABS_MAX_POS, {any8(), 8'(abs_max)});
      write_reg(CSR_ABS_MAX_SPEED, {any8(), 8'(abs_spd)});
      if ($urandom_range(0, 2) == 0)
         write_reg(CSR_SPARE, 16'($urandom));
      csr_valid   <= 1'b0;
      cur_abs_min = abs_min;
      cur_abs_max = abs_max;
      cur_abs_spd = abs_spd;
   endtask

   // random request mix; set-limit requests are mostly legal so the servos stay usable
   task automatic random_request();
      int r, lo, hi;
      logic [7:0] idx;
      r   = $urandom_range(0, 99);
      idx = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(SERVO_COUNT, 255))
                                         : 8'($urandom_range(0, SERVO_COUNT - 1));
      if (r < 45) begin
         send_request(OP_MOVE, idx, any8(), any8(), any8(), any8(), any8());
      end else if (r < 70) begin
         send_request(OP_TICK, any8(), any8(), any8(), any8(), any8(), any8());
      end else if (r < 80) begin
         send_request(OP_RESET, any8(), any8(), any8(), any8(), any8(), any8());
      end else if (cur_abs_min < cur_abs_max && $urandom_range(0, 4) != 0) begin
         lo = int'($urandom_range(cur_abs_min + 128, cur_abs_max + 127)) - 128;
         hi = int'($urandom_range(lo + 129, cur_abs_max + 128)) - 128;
         send_request(OP_SET_LIMIT, idx, any8(), any8(), 8'(lo), 8'(hi),
                      8'($urandom_range(0, cur_abs_spd)));
      end else begin
         send_request(OP_SET_LIMIT, idx, any8(), any8(), any8(), any8(), any8());
      end
      if ($urandom_range(0, 24) == 0)
         drain_responses();
   endtask

   initial begin
      reset               <= 1'b1;
      req_valid           <= 1'b0;
      req_opcode          <= OP_MOVE;
      req_servo_index     <= '0;
      req_position        <= '0;
      req_speed           <= '0;
      req_new_limit_low   <= '0;
      req_new_limit_high  <= '0;
      req_new_speed_limit <= '0;
      csr_valid           <= 1'b0;
      csr_index           <= CSR_NEUTRAL_PULSE;
      csr_data            <= '0;
      no_gaps     = 1'b0;
      cur_abs_min = -127;
      cur_abs_max = 127;
      cur_abs_spd = 255;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: default registers, clip mode
      send_request(OP_TICK, any8(), any8(), any8(), any8(), any8(), any8());
      send_request(OP_MOVE, 8'd0, 8'sd127, 8'd255, any8(), any8(), any8());
      send_request(OP_MOVE, 8'd7, -8'sd128, 8'd0, any8(), any8(), any8());
      send_request(OP_MOVE, 8'd3, 8'sd5, 8'd1, any8(), any8(), any8());
      send_request(OP_TICK, any8(), any8(), any8(), any8(), any8(), any8());
      send_request(OP_TICK, any8(), any8(), any8(), any8(), any8(), any8());
      send_request(OP_SET_LIMIT, 8'd2, any8(), any8(), -8'sd10, 8'sd10, 8'd20);
      send_request(OP_MOVE, 8'd2, 8'sd50, 8'd200, any8(), any8(), any8());
      send_request(OP_MOVE, 8'd2, -8'sd50, 8'd20, any8(), any8(), any8());
      send_request(OP_TICK, any8(), any8(), any8(), any8(), any8(), any8());
      // low equal to high is a limit fault; moves still land while it is latched
      send_request(OP_SET_LIMIT, 8'd1, any8(), any8(), 8'sd5, 8'sd5, 8'd9);
      send_request(OP_MOVE, 8'd4, 8'sd3, 8'd3, any8(), any8(), any8());
      send_request(OP_TICK, any8(), any8(), any8(), any8(), any8(), any8());
      send_request(OP_RESET, any8(), any8(), any8(), any8(), any8(), any8());
      // index faults, then limits at and beyond the absolute bounds
      send_request(OP_MOVE, 8'd8, 8'sd1, 8'd1, any8(), any8(), any8());
      send_request(OP_RESET, any8(), any8(), any8(), any8(), any8(), any8());
      send_request(OP_SET_LIMIT, 8'd255, any8(), any8(), -8'sd1, 8'sd1, 8'd1);
      send_request(OP_SET_LIMIT, 8'd5, any8(), any8(), -8'sd128, 8'sd127, 8'd255);
      send_request(OP_RESET, any8(), any8(), any8(), any8(), any8(), any8());
      send_request(OP_SET_LIMIT, 8'd6, any8(), any8(), -8'sd127, 8'sd127, 8'd255);
      // strict mode with a speed bound below the stored limits: reset must refuse
      drain_responses();
      program_config(NEUTRAL_RST, PPU_RST, 1'b1, -127, 127, 100);
      send_request(OP_RESET, any8(), any8(), any8(), any8(), any8(), any8());
      send_request(OP_MOVE, 8'd0, -8'sd128, 8'd10, any8(), any8(), any8());
      send_request(OP_MOVE, 8'd1, 8'sd0, 8'd0, any8(), any8(), any8());
      send_request(OP_TICK, any8(), any8(), any8(), any8(), any8(), any8());

      // random phases, each under its own register setting
      for (int ph = 0; ph < PHASES; ph++) begin
         drain_responses();
         case (ph)
            0: program_config(16'hFFFF, 8'hFF, 1'b0, -128, 127, 255);
            1: program_config(16'h0000, 8'h00, 1'b1, -1, 0, 0);
            default: program_config(16'($urandom), any8(), 1'($urandom),
                                    -int'($urandom_range(0, 128)),
                                    int'($urandom_range(0, 127)),
                                    int'($urandom_range(0, 255)));
         endcase
         no_gaps = (ph == 2);
         repeat (RANDOM_ITEMS / PHASES) random_request();
      end

      drain_responses();
      repeat (60) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
